// File: hw/rtl/cte_pkg.sv
`timescale 1ns / 1ps
// Package for the clock date and time editor: item types, operation, button
// and cursor codes, field limits and the shared wrap function. No dependencies.
package cte_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PRESS = 2'd1;
    localparam logic [1:0] OP_HOLD  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] BTN_BACK    = 2'd0;
    localparam logic [1:0] BTN_UP      = 2'd1;
    localparam logic [1:0] BTN_DOWN    = 2'd2;
    localparam logic [1:0] BTN_FORWARD = 2'd3;

    localparam logic [2:0] FIELD_HOUR    = 3'd0;
    localparam logic [2:0] FIELD_MINUTE  = 3'd1;
    localparam logic [2:0] FIELD_SECOND  = 3'd2;
    localparam logic [2:0] FIELD_WEEKDAY = 3'd3;
    localparam logic [2:0] FIELD_DAY     = 3'd4;
    localparam logic [2:0] FIELD_MONTH   = 3'd5;
    localparam logic [2:0] FIELD_YEAR    = 3'd6;

    localparam logic [5:0] HOUR_MAX    = 6'd23;
    localparam logic [5:0] MINUTE_MAX  = 6'd59;
    localparam logic [5:0] SECOND_MAX  = 6'd59;
    localparam logic [5:0] WEEKDAY_MAX = 6'd6;
    localparam logic [5:0] DAY_MAX     = 6'd31;
    localparam logic [5:0] MONTH_MAX   = 6'd12;
    localparam logic [5:0] ZERO_MIN    = 6'd0;
    localparam logic [5:0] ONE_MIN     = 6'd1;
    localparam logic [11:0] YEAR_MAX   = 12'd4095;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  button;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [5:0]  new_second;
        logic [2:0]  new_weekday;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [11:0] new_year;
    } t_in_item;

    typedef struct packed {
        logic        leave_edit;
        logic [2:0]  selected_field;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [2:0]  out_weekday;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [11:0] out_year;
    } t_out_item;

    // Steps a field by one when it is selected, then folds it back into
    // lo..hi: below the range gives hi, above it gives lo.
    function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic sel,
                                             input logic up, input logic [5:0] lo,
                                             input logic [5:0] hi);
        logic signed [7:0] t;
        t = $signed({2'b00, v});
        if (sel) begin
            t = up ? t + 8'sd1 : t - 8'sd1;
        end
        if (t < $signed({2'b00, lo})) begin
            wrap_step = hi;
        end else if (t > $signed({2'b00, hi})) begin
            wrap_step = lo;
        end else begin
            wrap_step = t[5:0];
        end
    endfunction

endpackage

// File: hw/rtl/cte_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the editor's input and result items.
// Depends on cte_pkg for the payload types.
interface cte_in_if;
    import cte_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface cte_out_if;
    import cte_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// File: hw/rtl/cte_editor.sv
`timescale 1ns / 1ps
// Editor state (cursor, hold enable, seven date and time fields) and the
// next-state logic for one item. Depends on cte_pkg.
module cte_editor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  cte_pkg::t_in_item  i_item,
    output cte_pkg::t_out_item o_result
);
    import cte_pkg::*;

    logic [2:0]  r_cur_field, n_cur_field;
    logic        r_hold_ok, n_hold_ok;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic [2:0]  r_weekday, n_weekday;
    logic [4:0]  r_day, n_day;
    logic [3:0]  r_month, n_month;
    logic [11:0] r_year, n_year;

    logic        leave;
    logic        adj_en;
    logic        adj_up;
    logic        move_prev;
    logic        move_next;
    logic [2:0]  prev_field;
    logic [2:0]  next_field;
    logic [5:0]  w_hour, w_minute, w_second, w_weekday, w_day, w_month;
    logic [11:0] w_year;

    assign prev_field = (r_cur_field == FIELD_HOUR) ? FIELD_YEAR : r_cur_field - 3'd1;
    assign next_field = (r_cur_field >= FIELD_YEAR) ? FIELD_HOUR : r_cur_field + 3'd1;

    always_comb begin
        leave     = 1'b0;
        adj_en    = 1'b0;
        adj_up    = 1'b0;
        move_prev = 1'b0;
        move_next = 1'b0;
        n_hold_ok = r_hold_ok;
        if (i_item.op == OP_LOAD) begin
            n_hold_ok = 1'b0;
        end else if (i_item.op == OP_PRESS) begin
            n_hold_ok = 1'b1;
            unique case (i_item.button)
                BTN_BACK: begin
                    if (r_cur_field == FIELD_HOUR) leave = 1'b1;
                    else move_prev = 1'b1;
                end
                BTN_UP: begin
                    adj_en = 1'b1;
                    adj_up = 1'b1;
                end
                BTN_DOWN: begin
                    adj_en = 1'b1;
                end
                BTN_FORWARD: begin
                    if (r_cur_field == FIELD_YEAR) leave = 1'b1;
                    else move_next = 1'b1;
                end
            endcase
        end else if (i_item.op == OP_HOLD && r_hold_ok) begin
            unique case (i_item.button)
                BTN_BACK:    move_prev = 1'b1;
                BTN_UP: begin
                    adj_en = 1'b1;
                    adj_up = 1'b1;
                end
                BTN_DOWN:    adj_en = 1'b1;
                BTN_FORWARD: move_next = 1'b1;
            endcase
        end
    end

    // Every adjustment re-checks all fields, so out-of-range loaded values
    // are folded back in on the first step of any field.
    assign w_hour    = wrap_step({1'b0, r_hour}, r_cur_field == FIELD_HOUR, adj_up,
                                 ZERO_MIN, HOUR_MAX);
    assign w_minute  = wrap_step(r_minute, r_cur_field == FIELD_MINUTE, adj_up,
                                 ZERO_MIN, MINUTE_MAX);
    assign w_second  = wrap_step(r_second, r_cur_field == FIELD_SECOND, adj_up,
                                 ZERO_MIN, SECOND_MAX);
    assign w_weekday = wrap_step({3'b000, r_weekday}, r_cur_field == FIELD_WEEKDAY, adj_up,
                                 ZERO_MIN, WEEKDAY_MAX);
    assign w_day     = wrap_step({1'b0, r_day}, r_cur_field == FIELD_DAY, adj_up,
                                 ONE_MIN, DAY_MAX);
    assign w_month   = wrap_step({2'b00, r_month}, r_cur_field == FIELD_MONTH, adj_up,
                                 ONE_MIN, MONTH_MAX);

    always_comb begin
        w_year = r_year;
        if (r_cur_field == FIELD_YEAR) begin
            if (adj_up) begin
                if (r_year != YEAR_MAX) w_year = r_year + 12'd1;
            end else begin
                if (r_year != 12'd0) w_year = r_year - 12'd1;
            end
        end
    end

    always_comb begin
        n_cur_field = r_cur_field;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        n_weekday   = r_weekday;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        if (i_item.op == OP_LOAD) begin
            n_cur_field = FIELD_HOUR;
            n_hour      = i_item.new_hour;
            n_minute    = i_item.new_minute;
            n_second    = i_item.new_second;
            n_weekday   = i_item.new_weekday;
            n_day       = i_item.new_day;
            n_month     = i_item.new_month;
            n_year      = i_item.new_year;
        end else if (adj_en) begin
            n_hour    = w_hour[4:0];
            n_minute  = w_minute;
            n_second  = w_second;
            n_weekday = w_weekday[2:0];
            n_day     = w_day[4:0];
            n_month   = w_month[3:0];
            n_year    = w_year;
        end else if (move_prev) begin
            n_cur_field = prev_field;
        end else if (move_next) begin
            n_cur_field = next_field;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_field <= FIELD_HOUR;
            r_hold_ok   <= 1'b0;
            r_hour      <= 5'd0;
            r_minute    <= 6'd0;
            r_second    <= 6'd0;
            r_weekday   <= 3'd0;
            r_day       <= 5'd1;
            r_month     <= 4'd1;
            r_year      <= 12'd0;
        end else if (i_take) begin
            r_cur_field <= n_cur_field;
            r_hold_ok   <= n_hold_ok;
            r_hour      <= n_hour;
            r_minute    <= n_minute;
            r_second    <= n_second;
            r_weekday   <= n_weekday;
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
        end
    end

    assign o_result.leave_edit     = leave;
    assign o_result.selected_field = n_cur_field;
    assign o_result.out_hour       = n_hour;
    assign o_result.out_minute     = n_minute;
    assign o_result.out_second     = n_second;
    assign o_result.out_weekday    = n_weekday;
    assign o_result.out_day        = n_day;
    assign o_result.out_month      = n_month;
    assign o_result.out_year       = n_year;

`ifndef NO_ASSERTIONS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_field <= FIELD_YEAR)
        else $error("cursor beyond the year field");
    a_load_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.op == OP_LOAD |=> r_cur_field == FIELD_HOUR && !r_hold_ok)
        else $error("load did not home the cursor or block holds");
    a_leave_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && leave |=> $stable(r_cur_field) && $stable(r_year) && r_hold_ok)
        else $error("leaving press altered the cursor or values");
`endif

endmodule

// File: hw/rtl/cte_out_skid.sv
`timescale 1ns / 1ps
// Result register with a skid stage, so the input side keeps a registered
// ready while the result side stalls. Depends on cte_pkg and cte_if.
module cte_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  cte_pkg::t_out_item i_item,
    output logic               o_in_ready,
    cte_out_if.source          o_out
);
    import cte_pkg::*;

    logic      r_out_v, n_out_v;
    logic      r_skid_v, n_skid_v;
    t_out_item r_out, n_out;
    t_out_item r_skid, n_skid;
    logic      out_done;

    assign out_done   = r_out_v && o_out.ready;
    assign o_in_ready = !r_skid_v;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (i_take) begin
            if (!r_out_v || out_done) begin
                n_out   = i_item;
                n_out_v = 1'b1;
            end else begin
                n_skid   = i_item;
                n_skid_v = 1'b1;
            end
        end else if (r_skid_v && out_done) begin
            n_out    = r_skid;
            n_skid_v = 1'b0;
        end else if (out_done) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held with an empty result register");
    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> !r_skid_v)
        else $error("transfer accepted with the skid stage full");
`endif

endmodule

// File: hw/rtl/clock_time_field_editor.sv
`timescale 1ns / 1ps
// Date and time field editor: every input transfer (load, button press or
// button hold) yields exactly one result transfer showing the cursor, the
// leave flag and all seven fields after that step. One item per clock is
// accepted while the skid stage is empty; each result is registered in the
// result register, and a skid stage keeps the input ready for one more item
// while the result side stalls. Depends on cte_pkg, cte_if, cte_editor and
// cte_out_skid.
module clock_time_field_editor (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cte_in_if.sink    i_in,
    cte_out_if.source o_out
);
    import cte_pkg::*;

    logic      take;
    logic      in_ready;
    t_out_item result;

    assign take       = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    cte_editor u_editor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (i_in.payload),
        .o_result (result)
    );

    cte_out_skid u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (result),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

endmodule

// File: dv/clock_time_field_editor_tb.sv
`timescale 1ns / 1ps
// Testbench for clock_time_field_editor: directed and random edit sessions, each
// checked against an in-bench prediction of the edited date and time.
// Depends on cte_pkg, cte_if and the editor RTL.
module clock_time_field_editor_tb;
    import cte_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 900;

    logic i_clk;
    logic i_rst_n;

    cte_in_if  in_if();
    cte_out_if out_if();

    clock_time_field_editor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted editor state, kept as plain integers so that out of range
    // values can step past the field width before they are folded back.
    logic [2:0] cursor;
    bit         holds_enabled;
    int         hr, mi, se, wd, dy, mo, yr;

    t_out_item edited_time_q[$];
    t_out_item want;

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int items_sent;
    int results_seen;
    int loads_sent;
    int leaves_seen;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic int fold(input int v, input int lo, input int hi);
        if (v < lo) begin
            return hi;
        end else if (v > hi) begin
            return lo;
        end
        return v;
    endfunction

    function automatic void bump_selected(input int delta);
        case (cursor)
            FIELD_HOUR:    hr += delta;
            FIELD_MINUTE:  mi += delta;
            FIELD_SECOND:  se += delta;
            FIELD_WEEKDAY: wd += delta;
            FIELD_DAY:     dy += delta;
            FIELD_MONTH:   mo += delta;
            FIELD_YEAR:    yr += delta;
            default: ;
        endcase
        // Every field but the year is folded, not just the one that moved; the year is clamped.
        hr = fold(hr, 0, 23);
        mi = fold(mi, 0, 59);
        se = fold(se, 0, 59);
        wd = fold(wd, 0, 6);
        dy = fold(dy, 1, 31);
        mo = fold(mo, 1, 12);
        if (yr < 0) begin
            yr = 0;
        end
        if (yr > 4095) begin
            yr = 4095;
        end
    endfunction

    function automatic t_out_item apply_edit(input t_in_item it);
        t_out_item r;
        logic      leave;
        leave = 1'b0;
        case (it.op)
            OP_LOAD: begin
                hr = int'(it.new_hour);
                mi = int'(it.new_minute);
                se = int'(it.new_second);
                wd = int'(it.new_weekday);
                dy = int'(it.new_day);
                mo = int'(it.new_month);
                yr = int'(it.new_year);
                cursor = FIELD_HOUR;
                holds_enabled = 1'b0;
            end
            OP_PRESS: begin
                holds_enabled = 1'b1;
                case (it.button)
                    BTN_BACK: begin
                        if (cursor == FIELD_HOUR) begin
                            leave = 1'b1;
                        end else begin
                            cursor = cursor - 3'd1;
                        end
                    end
                    BTN_UP:   bump_selected(1);
                    BTN_DOWN: bump_selected(-1);
                    default: begin
                        if (cursor == FIELD_YEAR) begin
                            leave = 1'b1;
                        end else begin
                            cursor = cursor + 3'd1;
                        end
                    end
                endcase
            end
            OP_HOLD: begin
                if (holds_enabled) begin
                    case (it.button)
                        BTN_BACK: cursor = (cursor == FIELD_HOUR) ? FIELD_YEAR : cursor - 3'd1;
                        BTN_UP:   bump_selected(1);
                        BTN_DOWN: bump_selected(-1);
                        default:  cursor = (cursor >= FIELD_YEAR) ? FIELD_HOUR : cursor + 3'd1;
                    endcase
                end
            end
            default: ;
        endcase
        r.leave_edit     = leave;
        r.selected_field = cursor;
        r.out_hour       = hr[4:0];
        r.out_minute     = mi[5:0];
        r.out_second     = se[5:0];
        r.out_weekday    = wd[2:0];
        r.out_day        = dy[4:0];
        r.out_month      = mo[3:0];
        r.out_year       = yr[11:0];
        return r;
    endfunction

    function automatic t_in_item random_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item load_item(input int h, input int m, input int s,
                                           input int w, input int d, input int mn,
                                           input int y);
        t_in_item it;
        it             = random_word();
        it.op          = OP_LOAD;
        it.new_hour    = 5'(h);
        it.new_minute  = 6'(m);
        it.new_second  = 6'(s);
        it.new_weekday = 3'(w);
        it.new_day     = 5'(d);
        it.new_month   = 4'(mn);
        it.new_year    = 12'(y);
        return it;
    endfunction

    // Called and left at a falling edge; valid stays high across back to back
    // transfers, so it sees a single assignment per edge.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        edited_time_q.push_back(apply_edit(it));
        items_sent++;
        if (it.op == OP_LOAD) begin
            loads_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_button(input logic [1:0] op, input logic [1:0] btn);
        t_in_item it;
        it        = random_word();
        it.op     = op;
        it.button = btn;
        send_item(it);
    endtask

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (edited_time_q.size() == 0) begin
                $display("%0t ns: result transfer with nothing expected, got %p",
                         $time, out_if.payload);
                errors++;
            end else begin
                want = edited_time_q.pop_front();
                if (out_if.payload.leave_edit) begin
                    leaves_seen++;
                end
                report_field("leave_edit", want.leave_edit, out_if.payload.leave_edit);
                report_field("selected_field", want.selected_field,
                             out_if.payload.selected_field);
                report_field("out_hour", want.out_hour, out_if.payload.out_hour);
                report_field("out_minute", want.out_minute, out_if.payload.out_minute);
                report_field("out_second", want.out_second, out_if.payload.out_second);
                report_field("out_weekday", want.out_weekday, out_if.payload.out_weekday);
                report_field("out_day", want.out_day, out_if.payload.out_day);
                report_field("out_month", want.out_month, out_if.payload.out_month);
                report_field("out_year", want.out_year, out_if.payload.out_year);
            end
        end
    end

    // Counts cycles in which no transfer happens on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("clock_time_field_editor test failed");
            $finish;
        end
    end

    task automatic test_after_reset();
        // A hold straight after reset is blocked and shows the reset values.
        send_button(OP_HOLD, BTN_UP);
        send_button(OP_NONE, BTN_DOWN);
    endtask

    task automatic test_load_extremes();
        send_item(load_item(23, 59, 59, 6, 31, 12, 4095));
        send_button(OP_HOLD, BTN_UP);
        send_button(OP_PRESS, BTN_UP);
        send_button(OP_PRESS, BTN_DOWN);
    endtask

    task automatic test_cursor_and_leave();
        send_button(OP_PRESS, BTN_BACK);
        send_button(OP_HOLD, BTN_BACK);
        send_button(OP_PRESS, BTN_UP);
        send_button(OP_PRESS, BTN_FORWARD);
        send_button(OP_HOLD, BTN_FORWARD);
    endtask

    task automatic test_field_wrap();
        send_item(load_item(0, 0, 0, 0, 1, 1, 0));
        send_button(OP_HOLD, BTN_FORWARD);
        send_button(OP_PRESS, BTN_FORWARD);
        send_button(OP_PRESS, BTN_DOWN);
        send_button(OP_HOLD, BTN_BACK);
        send_button(OP_HOLD, BTN_BACK);
        send_button(OP_PRESS, BTN_DOWN);
    endtask

    task automatic test_out_of_range_load();
        // Values beyond the field ranges are stored, then folded on the next step.
        send_item(load_item(31, 63, 63, 7, 0, 15, 4095));
        send_button(OP_PRESS, BTN_UP);
        send_item(load_item(24, 60, 60, 7, 0, 0, 0));
        send_button(OP_PRESS, BTN_DOWN);
        send_button(OP_NONE, BTN_FORWARD);
    endtask

    task automatic random_session();
        t_in_item it;
        int       steps;
        int       roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            it    = random_word();
            it.op = OP_LOAD;
        end else begin
            it = load_item($urandom_range(23), $urandom_range(59), $urandom_range(59),
                           $urandom_range(6), $urandom_range(1, 31), $urandom_range(1, 12),
                           (roll == 1) ? 4095 : (roll == 2) ? $urandom_range(2) :
                           $urandom_range(4095));
        end
        send_item(it);
        steps = $urandom_range(4, 20);
        repeat (steps) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                send_button(OP_PRESS, 2'($urandom_range(3)));
            end else if (roll < 95) begin
                send_button(OP_HOLD, 2'($urandom_range(3)));
            end else begin
                send_button(OP_NONE, 2'($urandom_range(3)));
            end
        end
    endtask

    task automatic test_random_sessions(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            random_session();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        out_if.ready   = 1'b0;
        errors         = 0;
        items_sent     = 0;
        results_seen   = 0;
        loads_sent     = 0;
        leaves_seen    = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 17;
        recv_idle_pct  = 75;
        cursor         = FIELD_HOUR;
        holds_enabled  = 1'b0;
        hr = 0; mi = 0; se = 0; wd = 0; dy = 1; mo = 1; yr = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_after_reset();
        test_load_extremes();
        test_cursor_and_leave();
        test_field_wrap();
        test_out_of_range_load();

        test_random_sessions(RANDOM_ITEMS / 3);
        send_idle_pct = 75;
        recv_idle_pct = 17;
        test_random_sessions(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sessions(RANDOM_ITEMS / 3);

        in_if.valid <= 1'b0;
        while (edited_time_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);

        $display("Sent %0d items (%0d loads) under three stall patterns; %0d results checked.",
                 items_sent, loads_sent, results_seen);
        $display("Editing was left %0d times; %0d field mismatches.", leaves_seen, errors);
        if (errors == 0 && edited_time_q.size() == 0) begin
            $display("clock_time_field_editor test passed");
        end else begin
            $display("clock_time_field_editor test failed");
        end
        $finish;
    end

endmodule
